>>> hw/rtl/nld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nld_pkg
// Shared constants for the network ASCII line-end decoder: character codes,
// register indexes and the register reset values.
// ----------------------------------------------------------------------------
package nld_pkg;

	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	// The newline byte register holds four bytes.
	localparam int REG_BYTE_CAP = 4;

	localparam int NL_LEN_W   = 3;
	localparam int NL_BYTES_W = 8 * REG_BYTE_CAP;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEWLINE_LENGTH = 1'b0,
		REG_NEWLINE_BYTES  = 1'b1
	} cfg_reg_t;

	localparam logic [NL_LEN_W-1:0]   NL_LEN_RESET   = 3'd1;
	localparam logic [NL_BYTES_W-1:0] NL_BYTES_RESET = 32'h0000_000A;

endpackage : nld_pkg
`default_nettype wire

>>> hw/rtl/nld_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nld_decode
// Combinational decode of one network byte against the held-CR flag into a
// short list of local bytes, its length and the next held-CR flag.
// ----------------------------------------------------------------------------
module nld_decode #(
	parameter int MAX_NEWLINE_BYTES = 4,
	parameter int DEPTH             = 4,
	parameter int CW                = 3
) (
	input  wire logic [7:0]                     in_byte,
	input  wire logic                           end_of_block,
	input  wire logic                           pending_cr,
	input  wire logic [nld_pkg::NL_LEN_W-1:0]   newline_length,
	input  wire logic [nld_pkg::NL_BYTES_W-1:0] newline_bytes,
	output logic      [7:0]                     dec_bytes [DEPTH],
	output logic      [CW-1:0]                  dec_count,
	output logic                                pending_next
);

	// Usable newline length is bounded by the parameter and the register size.
	localparam int NL_CAP = (MAX_NEWLINE_BYTES < nld_pkg::REG_BYTE_CAP) ?
		MAX_NEWLINE_BYTES : nld_pkg::REG_BYTE_CAP;
	localparam logic [nld_pkg::NL_LEN_W-1:0] NL_CAP_V = nld_pkg::NL_LEN_W'(NL_CAP);

	logic [nld_pkg::NL_LEN_W-1:0] eff_len;
	logic                         is_cr;
	logic                         hold_cr;

	always_comb begin
		if (newline_length == '0) begin
			eff_len = nld_pkg::NL_LEN_W'(1);
		end else if (newline_length > NL_CAP_V) begin
			eff_len = NL_CAP_V;
		end else begin
			eff_len = newline_length;
		end
	end

	assign is_cr   = (in_byte == nld_pkg::CHAR_CR);
	assign hold_cr = is_cr && !end_of_block;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			dec_bytes[i] = '0;
		end
		dec_count    = '0;
		pending_next = 1'b0;

		if (pending_cr && (in_byte == nld_pkg::CHAR_LF)) begin
			for (int i = 0; i < DEPTH; i++) begin
				dec_bytes[i] = (i < NL_CAP) ? newline_bytes[8*i +: 8] : 8'h00;
			end
			dec_count = CW'(eff_len);
		end else if (pending_cr && (in_byte == nld_pkg::CHAR_NUL)) begin
			dec_bytes[0] = nld_pkg::CHAR_CR;
			dec_count    = CW'(1);
		end else if (pending_cr) begin
			// The held CR goes out first; the new byte is then taken as usual.
			dec_bytes[0] = nld_pkg::CHAR_CR;
			if (hold_cr) begin
				pending_next = 1'b1;
				dec_count    = CW'(1);
			end else begin
				dec_bytes[1] = in_byte;
				dec_count    = CW'(2);
			end
		end else if (hold_cr) begin
			pending_next = 1'b1;
		end else begin
			dec_bytes[0] = in_byte;
			dec_count    = CW'(1);
		end
	end

endmodule : nld_decode
`default_nettype wire

>>> hw/rtl/netascii_line_end_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The first result of an accepted transaction appears on m_* in the next cycle.
// Throughput: one transaction per cycle while m_tready is high and each
// byte yields at most one result; CR LF expands to newline_length (clamped)
// results, CR and a plain byte to two; the input waits while the buffer drains.
// Reset: arst_n clears the held-CR flag and the result count and restores
// newline_length to 1 and newline_bytes to LF.
// ----------------------------------------------------------------------------
// netascii_line_end_decoder_unit
// Converts a network ASCII byte stream to local line endings. A CR not marked
// s_tlast is held until the next byte decides its meaning: CR LF becomes the
// configured local newline, CR NUL becomes CR, and any other CR passes as CR.
// ----------------------------------------------------------------------------
module netascii_line_end_decoder_unit #(
	parameter int MAX_NEWLINE_BYTES = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	// Configuration write port.
	input  wire logic                            cfg_we,
	input  wire logic [nld_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [nld_pkg::NL_BYTES_W-1:0]  cfg_wdata,

	// Input stream.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,   // [7:0] in_byte
	input  wire logic                            s_tlast,   // end_of_block

	// Output stream.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [7:0]                      m_tdata,   // [7:0] out_byte
	output logic                                 m_tlast    // out_last
);

	// Usable newline length, and the result buffer depth. The buffer must also
	// hold a flushed CR plus the following byte, so it is never under two.
	localparam int NL_CAP = (MAX_NEWLINE_BYTES < nld_pkg::REG_BYTE_CAP) ?
		MAX_NEWLINE_BYTES : nld_pkg::REG_BYTE_CAP;
	localparam int DEPTH  = (NL_CAP > 2) ? NL_CAP : 2;
	localparam int IW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);

	// Configuration registers.
	logic [nld_pkg::NL_LEN_W-1:0]   nl_len_q;
	logic [nld_pkg::NL_BYTES_W-1:0] nl_bytes_q;

	// Held-CR state and the result buffer that drains onto m_*.
	logic              pending_cr_q;
	logic [7:0]        buf_q [DEPTH];
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     idx_q;

	logic [7:0]        dec_bytes [DEPTH];
	logic [CW-1:0]     dec_count;
	logic              pending_next;

	logic              in_fire;
	logic              out_fire;
	logic              on_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_len_q   <= nld_pkg::NL_LEN_RESET;
			nl_bytes_q <= nld_pkg::NL_BYTES_RESET;
		end else if (cfg_we) begin
			case (nld_pkg::cfg_reg_t'(cfg_index))
				nld_pkg::REG_NEWLINE_LENGTH: begin
					nl_len_q <= cfg_wdata[nld_pkg::NL_LEN_W-1:0];
				end
				nld_pkg::REG_NEWLINE_BYTES: begin
					nl_bytes_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	nld_decode #(
		.MAX_NEWLINE_BYTES (MAX_NEWLINE_BYTES),
		.DEPTH             (DEPTH),
		.CW                (CW)
	) u_decode (
		.in_byte        (s_tdata),
		.end_of_block   (s_tlast),
		.pending_cr     (pending_cr_q),
		.newline_length (nl_len_q),
		.newline_bytes  (nl_bytes_q),
		.dec_bytes      (dec_bytes),
		.dec_count      (dec_count),
		.pending_next   (pending_next)
	);

	// The buffer is busy while it holds results. A new transaction is taken
	// when the buffer is empty or its final result leaves in this cycle, so a
	// stream of single-result bytes moves at one per cycle while m_tready is high.
	assign m_tvalid = (cnt_q != '0);
	assign on_last  = ((CW'(idx_q) + CW'(1)) == cnt_q);
	assign m_tlast  = on_last;
	assign m_tdata  = buf_q[idx_q];

	assign out_fire = m_tvalid && m_tready;
	assign s_tready = !m_tvalid || (m_tready && on_last);
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_cr_q <= 1'b0;
			cnt_q        <= '0;
			idx_q        <= '0;
		end else if (in_fire) begin
			// A held CR produces no results, which leaves the buffer empty.
			pending_cr_q <= pending_next;
			cnt_q        <= dec_count;
			idx_q        <= '0;
		end else if (out_fire) begin
			if (on_last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Result bytes need no reset; they are only read under cnt_q.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < DEPTH; i++) begin
				buf_q[i] <= dec_bytes[i];
			end
		end
	end

endmodule : netascii_line_end_decoder_unit
`default_nettype wire

>>> hw/rtl/nld_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nld_checker
// Port-level checks for the line-end decoder, bound to the top level.
// ----------------------------------------------------------------------------
module nld_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// A stalled result stays offered.
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	// A stalled result keeps its payload.
	a_m_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("m_tdata or m_tlast changed while stalled");

	// With nothing waiting on the output, the input is always open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with an empty result buffer");

	// A transaction may only enter while the previous one is finishing.
	a_enter_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tvalid |-> m_tready && m_tlast)
		else $error("transaction accepted over undelivered results");

	// Only a CR in the middle of a transfer yields no result.
	a_some_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && ((s_tdata != nld_pkg::CHAR_CR) || s_tlast) |=> m_tvalid)
		else $error("transaction produced no result");

endmodule : nld_checker

bind netascii_line_end_decoder_unit nld_checker u_nld_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

>>> tb/sv/netascii_line_end_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// netascii_line_end_decoder_unit_tb
// Self-checking bench for the network ASCII line-end decoder. A clocked driver
// feeds input bytes from a queue, and an in-bench model of the held-CR logic
// predicts the decoded bytes of every accepted transaction. A clocked monitor
// compares each output transaction against the oldest prediction. The run
// goes through several newline settings, from one byte up to four, including
// the out-of-range lengths that must saturate.
// ----------------------------------------------------------------------------
module netascii_line_end_decoder_unit_tb;

	// The unit is built with its default newline capacity.
	localparam int NL_MAX = 4;

	// Least number of random input bytes in each configuration phase.
	localparam int PHASE_ITEMS = 52;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_block;
	} net_byte_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} local_byte_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [nld_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [nld_pkg::NL_BYTES_W-1:0] cfg_wdata = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata   = 8'h00;  // [7:0] in_byte
	logic                           s_tlast   = 1'b0;   // end_of_block
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [7:0]                     m_tdata;            // [7:0] out_byte
	logic                           m_tlast;            // out_last

	// Bytes waiting to be offered to the unit, and decoded bytes that the
	// unit still owes us, oldest first.
	net_byte_t   stream_bytes[$];
	local_byte_t decoded_bytes[$];

	// The model's copy of the unit's state and its two registers.
	logic                           cr_held      = 1'b0;
	logic [nld_pkg::NL_LEN_W-1:0]   nl_len_cfg   = nld_pkg::NL_LEN_RESET;
	logic [nld_pkg::NL_BYTES_W-1:0] nl_bytes_cfg = nld_pkg::NL_BYTES_RESET;

	// Per-phase switches for idle gaps on the input and stalls on the output.
	bit gaps_on   = 1'b0;
	bit stalls_on = 1'b0;

	int bytes_queued = 0;
	int fail_count   = 0;
	int gap_left     = 0;
	int stall_left   = 0;

	netascii_line_end_decoder_unit #(
		.MAX_NEWLINE_BYTES(NL_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idle lengths: mostly none, often a few cycles, now and then a long one.
	function automatic int draw_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 24);
	endfunction

	// Decodes one accepted input byte the way the unit must, and queues the
	// bytes it yields. A CR is held back until the next byte explains it; the
	// newline length is clamped into 1..NL_MAX and to the four register bytes.
	function automatic void predict_decode(logic [7:0] in_byte, logic end_of_block);
		local_byte_t burst[$];
		local_byte_t one;
		int          nl_len;
		bit          plain;
		plain = 1'b1;
		one.out_last = 1'b0;
		if (cr_held) begin
			cr_held = 1'b0;
			if (in_byte == nld_pkg::CHAR_LF) begin
				nl_len = int'(nl_len_cfg);
				if (nl_len < 1)
					nl_len = 1;
				if (nl_len > NL_MAX)
					nl_len = NL_MAX;
				if (nl_len > nld_pkg::REG_BYTE_CAP)
					nl_len = nld_pkg::REG_BYTE_CAP;
				for (int i = 0; i < nl_len; i++) begin
					one.out_byte = nl_bytes_cfg[8*i +: 8];
					burst = {burst, one};
				end
				plain = 1'b0;
			end else begin
				// CR NUL collapses to a bare CR; any other byte releases the
				// CR and is then decoded on its own below.
				one.out_byte = nld_pkg::CHAR_CR;
				burst = {burst, one};
				if (in_byte == nld_pkg::CHAR_NUL)
					plain = 1'b0;
			end
		end
		if (plain) begin
			if (in_byte == nld_pkg::CHAR_CR && !end_of_block) begin
				cr_held = 1'b1;
			end else begin
				one.out_byte = in_byte;
				burst = {burst, one};
			end
		end
		for (int i = 0; i < burst.size(); i++) begin
			one = burst[i];
			one.out_last = (i == burst.size() - 1);
			decoded_bytes = {decoded_bytes, one};
		end
	endfunction

	// Input driver: presents queued bytes, holds each one until the unit takes
	// it, and inserts random idle cycles between transactions when gaps_on is set.
	always @(posedge clk) begin : stream_driver
		net_byte_t nxt;
		bit        hold;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			hold = s_tvalid && !s_tready;
			if (s_tvalid && s_tready)
				predict_decode(s_tdata, s_tlast);
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (stream_bytes.size() > 0) begin
					nxt = stream_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.in_byte;
					s_tlast  <= nxt.end_of_block;
					gap_left = gaps_on ? draw_gap() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks every output transaction against the oldest
	// prediction and stalls the output at random when stalls_on is set.
	always @(posedge clk) begin : decoded_monitor
		local_byte_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (decoded_bytes.size() == 0) begin
					$error("unexpected output: out_byte %02h out_last %0b", m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = decoded_bytes.pop_front();
					if (m_tdata !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.out_last) begin
						$error("out_last: expected %0b, got %0b", want.out_last, m_tlast);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (stalls_on && $urandom_range(0, 99) < 20)
					stall_left = draw_gap();
			end
		end
	end

	task automatic push_byte(logic [7:0] in_byte, logic end_of_block);
		net_byte_t item;
		item.in_byte      = in_byte;
		item.end_of_block = end_of_block;
		stream_bytes = {stream_bytes, item};
		bytes_queued++;
	endtask

	// Queues one short piece of stream. Most pieces are CR sequences with
	// random content, so the held-CR paths get plenty of traffic; the rest
	// are plain bytes and noise with a random end-of-transfer flag.
	task automatic queue_random_piece();
		int         pick;
		logic       eob;
		logic [7:0] other;
		pick = $urandom_range(0, 99);
		eob  = ($urandom_range(0, 7) == 0);
		do
			other = 8'($urandom_range(0, 255));
		while (other == nld_pkg::CHAR_LF || other == nld_pkg::CHAR_NUL);
		if (pick < 25) begin
			push_byte(8'($urandom_range(0, 255)), eob);
		end else if (pick < 50) begin
			push_byte(nld_pkg::CHAR_CR, 1'b0);
			push_byte(nld_pkg::CHAR_LF, eob);
		end else if (pick < 60) begin
			push_byte(nld_pkg::CHAR_CR, 1'b0);
			push_byte(nld_pkg::CHAR_NUL, eob);
		end else if (pick < 70) begin
			push_byte(nld_pkg::CHAR_CR, 1'b0);
			push_byte(other, eob);
		end else if (pick < 78) begin
			push_byte(nld_pkg::CHAR_CR, 1'b1);
		end else if (pick < 86) begin
			push_byte(nld_pkg::CHAR_CR, 1'b0);
			push_byte(nld_pkg::CHAR_CR, 1'b0);
			push_byte(nld_pkg::CHAR_LF, eob);
		end else begin
			push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	// Waits until every byte has been taken and every decoded byte has come
	// back, then a few more cycles in case a CR is still held inside. The
	// check runs on the falling edge, after all clocked updates have settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (stream_bytes.size() != 0 || s_tvalid || m_tvalid ||
			decoded_bytes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(nld_pkg::cfg_reg_t idx, logic [nld_pkg::NL_BYTES_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == nld_pkg::REG_NEWLINE_LENGTH)
			nl_len_cfg = value[nld_pkg::NL_LEN_W-1:0];
		else
			nl_bytes_cfg = value;
	endtask

	initial begin : stimulus
		logic [nld_pkg::NL_LEN_W-1:0] phase_len[8];
		int                           start;
		phase_len = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd1, 3'd5, 3'd6};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset newline (a single LF), run at full rate
		// on both sides: field extremes, every CR pairing, a CR at the end of a
		// transfer, and a held CR released by a second CR.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b1);
		push_byte(nld_pkg::CHAR_CR, 1'b0);
		push_byte(nld_pkg::CHAR_LF, 1'b0);
		push_byte(nld_pkg::CHAR_CR, 1'b0);
		push_byte(nld_pkg::CHAR_NUL, 1'b0);
		push_byte(nld_pkg::CHAR_CR, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(nld_pkg::CHAR_CR, 1'b0);
		push_byte(nld_pkg::CHAR_CR, 1'b0);
		push_byte(nld_pkg::CHAR_LF, 1'b0);
		push_byte(nld_pkg::CHAR_CR, 1'b0);
		push_byte(nld_pkg::CHAR_CR, 1'b1);
		push_byte(nld_pkg::CHAR_CR, 1'b1);
		push_byte(nld_pkg::CHAR_CR, 1'b0);
		push_byte(nld_pkg::CHAR_LF, 1'b1);
		push_byte(nld_pkg::CHAR_CR, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(nld_pkg::CHAR_LF, 1'b0);
		push_byte(nld_pkg::CHAR_NUL, 1'b1);
		push_byte(nld_pkg::CHAR_CR, 1'b0);
		push_byte(nld_pkg::CHAR_NUL, 1'b1);
		wait_idle();

		// Random phases, one per newline setting. Lengths 0 and 5..7 check
		// the clamping; all-ones and all-zeros newline bytes are included.
		for (int p = 0; p < 8; p++) begin
			write_reg(nld_pkg::REG_NEWLINE_LENGTH, nld_pkg::NL_BYTES_W'(phase_len[p]));
			case (p)
				3:       write_reg(nld_pkg::REG_NEWLINE_BYTES, 32'hFFFF_FFFF);
				4:       write_reg(nld_pkg::REG_NEWLINE_BYTES, 32'h0000_0000);
				default: write_reg(nld_pkg::REG_NEWLINE_BYTES, 32'($urandom));
			endcase
			gaps_on   = (p % 3 != 0);
			stalls_on = (p % 3 != 1);
			start = bytes_queued;
			while (bytes_queued - start < PHASE_ITEMS)
				queue_random_piece();
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && decoded_bytes.size() == 0)
			$display("netascii_line_end_decoder_unit: match");
		else
			$display("netascii_line_end_decoder_unit: mismatch");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#1_000_000;
		$display("netascii_line_end_decoder_unit: mismatch");
		$finish;
	end

endmodule
